FILE: src/twfd_pkg.sv
`timescale 1ns / 1ps

package twfd_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int POS_W       = 6;
    localparam int SUM_W       = 40;
    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [WORD_W-1:0] HEADER_RESET = 32'd453;
    localparam logic [WORD_W-1:0] FOOTER_RESET = 32'd761;

    // payload words added without sign extension
    localparam logic [POS_W-1:0] UNSIGNED_POS_A = 6'd24;
    localparam logic [POS_W-1:0] UNSIGNED_POS_B = 6'd25;
    localparam int PAYLOAD_CAP = 55;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOOTER = 1'd1;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_FOOTER   = 2'd1,
        ERR_CHECKSUM = 2'd2
    } err_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CHECK,
        ST_STATUS,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } ctl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;      // byte accepted this edge
        logic evaluate;     // act on the byte just captured
        logic check;        // judge the finished frame
        logic emit_read;    // fetch payload word
        logic show_word;    // present payload word
        logic show_status;  // present status item
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hunting;
        logic frame_end;
        logic frame_bad;
        logic emit_last;
    } dp_status_t;

endpackage

FILE: src/twfd_ctrl.sv
`timescale 1ns / 1ps

module twfd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output twfd_pkg::dp_cmd_t     cmd,
    input  twfd_pkg::dp_status_t  status
);

    twfd_pkg::ctl_state_t state_reg;
    twfd_pkg::ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= twfd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            twfd_pkg::ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
                if (start)
                begin
                    state_next = twfd_pkg::ST_EVAL;
                end
            end
            twfd_pkg::ST_EVAL:
            begin
                cmd.evaluate = 1'b1;
                if (!status.hunting && status.frame_end)
                begin
                    state_next = twfd_pkg::ST_CHECK;
                end
                else
                begin
                    state_next = twfd_pkg::ST_IDLE;
                end
            end
            twfd_pkg::ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (status.frame_bad)
                begin
                    state_next = twfd_pkg::ST_STATUS;
                end
                else
                begin
                    state_next = twfd_pkg::ST_EMIT_RD;
                end
            end
            twfd_pkg::ST_STATUS:
            begin
                cmd.show_status = 1'b1;
                state_next      = twfd_pkg::ST_IDLE;
            end
            twfd_pkg::ST_EMIT_RD:
            begin
                cmd.emit_read = 1'b1;
                state_next    = twfd_pkg::ST_EMIT_OUT;
            end
            twfd_pkg::ST_EMIT_OUT:
            begin
                cmd.show_word = 1'b1;
                if (status.emit_last)
                begin
                    state_next = twfd_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = twfd_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = twfd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/twfd_datapath.sv
`timescale 1ns / 1ps

module twfd_datapath #(
    parameter int FRAME_WORDS = 58
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  twfd_pkg::dp_cmd_t                      cmd,
    output twfd_pkg::dp_status_t                   status,
    input  logic [twfd_pkg::BYTE_W-1:0]            rx_byte,
    input  logic                                   write_enable,
    input  logic [twfd_pkg::CFG_IDX_W-1:0]         write_index,
    input  logic [twfd_pkg::WORD_W-1:0]            write_data,
    output logic                                   strobe,
    output logic [twfd_pkg::POS_W-1:0]             word_index,
    output logic [twfd_pkg::WORD_W-1:0]            word_value,
    output logic                                   frame_ok,
    output logic [1:0]                             error_code,
    output logic                                   last_item,
    output logic [twfd_pkg::COUNT_W-1:0]           good_frames,
    output logic [twfd_pkg::COUNT_W-1:0]           dropped_frames
);

    localparam int POS_W   = twfd_pkg::POS_W;
    localparam int WORD_W  = twfd_pkg::WORD_W;
    localparam int BYTE_W  = twfd_pkg::BYTE_W;
    localparam int SUM_W   = twfd_pkg::SUM_W;
    localparam int COUNT_W = twfd_pkg::COUNT_W;
    localparam int PAYLOAD_RAW   = FRAME_WORDS - 3;
    localparam int PAYLOAD_WORDS = (PAYLOAD_RAW > twfd_pkg::PAYLOAD_CAP)
                                   ? twfd_pkg::PAYLOAD_CAP : PAYLOAD_RAW;
    localparam logic [POS_W-1:0] FOOTER_POS = POS_W'(FRAME_WORDS - 1);
    localparam logic [POS_W-1:0] CHK_POS    = POS_W'(FRAME_WORDS - 2);
    localparam logic [POS_W-1:0] LAST_PAY   = POS_W'(PAYLOAD_WORDS);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    logic [WORD_W-1:0]  header_reg;
    logic [WORD_W-1:0]  footer_reg;
    logic [WORD_W-1:0]  window_reg;
    logic               hunting_reg;
    logic [1:0]         byte_cnt_reg;
    logic [WORD_W-1:0]  shift_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [WORD_W-1:0]  chk_word_reg;
    logic               foot_bad_reg;
    twfd_pkg::err_code_t err_reg;
    logic [POS_W-1:0]   emit_k_reg;
    logic [COUNT_W-1:0] good_reg;
    logic [COUNT_W-1:0] drop_reg;

    logic [WORD_W-1:0]  store_mem [twfd_pkg::STORE_DEPTH];
    logic [WORD_W-1:0]  rd_data_reg;

    logic               word_done;
    logic               in_payload;
    logic               unsigned_pos;
    logic [SUM_W-1:0]   addend;
    logic [WORD_W-1:0]  sum_fold;
    logic               sum_bad;

    assign word_done    = !hunting_reg && (byte_cnt_reg == 2'd0);
    assign in_payload   = (pos_reg >= POS_W'(1)) && (pos_reg <= LAST_PAY);
    assign unsigned_pos = (pos_reg == twfd_pkg::UNSIGNED_POS_A)
                       || (pos_reg == twfd_pkg::UNSIGNED_POS_B);
    assign addend       = unsigned_pos ? {{(SUM_W-WORD_W){1'b0}}, shift_reg}
                                       : {{(SUM_W-WORD_W){shift_reg[WORD_W-1]}}, shift_reg};
    // low 31 bits plus the arithmetic high part, modulo 2^32
    assign sum_fold = {1'b0, sum_reg[30:0]}
                    + {{(WORD_W-(SUM_W-31)){sum_reg[SUM_W-1]}}, sum_reg[SUM_W-1:31]};
    assign sum_bad  = (sum_fold != chk_word_reg);

    assign status.hunting   = hunting_reg;
    assign status.frame_end = word_done && (pos_reg == FOOTER_POS);
    assign status.frame_bad = foot_bad_reg || sum_bad;
    assign status.emit_last = (emit_k_reg == LAST_PAY);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= twfd_pkg::HEADER_RESET;
            footer_reg <= twfd_pkg::FOOTER_RESET;
        end
        else if (write_enable)
        begin
            case (write_index)
                twfd_pkg::REG_HEADER: header_reg <= write_data;
                twfd_pkg::REG_FOOTER: footer_reg <= write_data;
                default: ;
            endcase
        end
    end

    // framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            hunting_reg  <= 1'b1;
            byte_cnt_reg <= '0;
            shift_reg    <= '0;
            pos_reg      <= '0;
            sum_reg      <= '0;
            chk_word_reg <= '0;
            foot_bad_reg <= 1'b0;
            err_reg      <= twfd_pkg::ERR_NONE;
            emit_k_reg   <= '0;
            good_reg     <= '0;
            drop_reg     <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                if (hunting_reg)
                begin
                    window_reg <= {rx_byte, window_reg[WORD_W-1:BYTE_W]};
                end
                else
                begin
                    shift_reg    <= {rx_byte, shift_reg[WORD_W-1:BYTE_W]};
                    byte_cnt_reg <= byte_cnt_reg + 2'd1;
                end
            end

            if (cmd.evaluate)
            begin
                if (hunting_reg)
                begin
                    if (window_reg == header_reg)
                    begin
                        hunting_reg  <= 1'b0;
                        pos_reg      <= POS_W'(1);
                        byte_cnt_reg <= '0;
                        shift_reg    <= '0;
                        sum_reg      <= '0;
                    end
                end
                else if (word_done)
                begin
                    if (in_payload)
                    begin
                        sum_reg <= sum_reg + addend;
                    end
                    if (pos_reg == CHK_POS)
                    begin
                        chk_word_reg <= shift_reg;
                    end
                    if (pos_reg == FOOTER_POS)
                    begin
                        foot_bad_reg <= (shift_reg != footer_reg);
                    end
                    else
                    begin
                        pos_reg <= pos_reg + POS_W'(1);
                    end
                end
            end

            if (cmd.check)
            begin
                // footer test wins over checksum
                if (foot_bad_reg)
                begin
                    err_reg <= twfd_pkg::ERR_FOOTER;
                end
                else if (sum_bad)
                begin
                    err_reg <= twfd_pkg::ERR_CHECKSUM;
                end
                else
                begin
                    err_reg <= twfd_pkg::ERR_NONE;
                end
                if (status.frame_bad)
                begin
                    if (drop_reg != COUNT_MAX)
                    begin
                        drop_reg <= drop_reg + COUNT_W'(1);
                    end
                end
                else if (good_reg != COUNT_MAX)
                begin
                    good_reg <= good_reg + COUNT_W'(1);
                end
                hunting_reg  <= 1'b1;
                window_reg   <= '0;
                pos_reg      <= '0;
                byte_cnt_reg <= '0;
                shift_reg    <= '0;
                sum_reg      <= '0;
                emit_k_reg   <= POS_W'(1);
            end

            if (cmd.show_word)
            begin
                emit_k_reg <= emit_k_reg + POS_W'(1);
            end
        end
    end

    // frame store
    always_ff @(posedge clk)
    begin
        if (cmd.evaluate && word_done)
        begin
            store_mem[pos_reg] <= shift_reg;
        end
        if (cmd.emit_read)
        begin
            rd_data_reg <= store_mem[emit_k_reg];
        end
    end

    // result item
    assign strobe         = cmd.show_word || cmd.show_status;
    assign word_index     = cmd.show_word ? emit_k_reg : '0;
    assign word_value     = cmd.show_word ? rd_data_reg : '0;
    assign frame_ok       = cmd.show_word;
    assign error_code     = cmd.show_status ? err_reg : twfd_pkg::ERR_NONE;
    assign last_item      = cmd.show_status || (cmd.show_word && status.emit_last);
    assign good_frames    = good_reg;
    assign dropped_frames = drop_reg;

endmodule

FILE: src/telemetry_word_frame_deframer_unit.sv
`timescale 1ns / 1ps

// Telemetry word-frame deframer. Bytes enter one at a time on start while
// busy is low; each byte passes through a capture state and then an
// evaluate state with busy high, so a new byte is not taken until the
// last one is evaluated. The byte that completes the footer word leads to
// a check state and then the result items: a bad frame gives one status
// item, a good frame gives its P payload words, P = min(FRAME_WORDS-3, 55),
// each read back from the frame store into a register before it is shown.
// Items appear on the result ports for exactly one cycle, flagged by
// strobe; the receiver cannot stall them, so it must take every item.
// Header and footer registers are written through write_enable; the user
// must write them only while the block is idle (the block does not enforce
// this); they take effect at once.

module telemetry_word_frame_deframer_unit #(
    parameter int FRAME_WORDS = 58
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // byte input
    input  logic                                  start,
    output logic                                  busy,
    input  logic [twfd_pkg::BYTE_W-1:0]           rx_byte,
    // register writes
    input  logic                                  write_enable,
    input  logic [twfd_pkg::CFG_IDX_W-1:0]        write_index,
    input  logic [twfd_pkg::WORD_W-1:0]           write_data,
    // result items
    output logic                                  strobe,
    output logic [twfd_pkg::POS_W-1:0]            word_index,
    output logic [twfd_pkg::WORD_W-1:0]           word_value,
    output logic                                  frame_ok,
    output logic [1:0]                            error_code,
    output logic                                  last_item,
    output logic [twfd_pkg::COUNT_W-1:0]          good_frames,
    output logic [twfd_pkg::COUNT_W-1:0]          dropped_frames
);

    twfd_pkg::dp_cmd_t    cmd;
    twfd_pkg::dp_status_t status;

    // sequencer: byte capture, word evaluation, frame check and readout
    twfd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    // hunt window, word assembly, checksum, frame store and counters
    twfd_datapath #(
        .FRAME_WORDS (FRAME_WORDS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .rx_byte        (rx_byte),
        .write_enable   (write_enable),
        .write_index    (write_index),
        .write_data     (write_data),
        .strobe         (strobe),
        .word_index     (word_index),
        .word_value     (word_value),
        .frame_ok       (frame_ok),
        .error_code     (error_code),
        .last_item      (last_item),
        .good_frames    (good_frames),
        .dropped_frames (dropped_frames)
    );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

// Deframer bench. Whole frames are built byte by byte (header, payload,
// checksum, footer) and pushed through the start/busy port in bursts with
// random gaps. Every accepted byte is fed to a behavioural copy of the
// deframer held in the scoreboard, which queues the items that byte should
// cause. Every strobed item is checked field by field against the oldest
// queued one. Registers are only rewritten once the block has gone quiet.
module tb_top;

    localparam int POS_W       = twfd_pkg::POS_W;
    localparam int WORD_W      = twfd_pkg::WORD_W;
    localparam int BYTE_W      = twfd_pkg::BYTE_W;
    localparam int SUM_W       = twfd_pkg::SUM_W;
    localparam int COUNT_W     = twfd_pkg::COUNT_W;
    localparam int CFG_IDX_W   = twfd_pkg::CFG_IDX_W;
    localparam int STORE_DEPTH = twfd_pkg::STORE_DEPTH;

    localparam int FRAME_LEN   = 58;
    localparam int PAYLOAD_LEN = (FRAME_LEN - 3 > twfd_pkg::PAYLOAD_CAP)
                                 ? twfd_pkg::PAYLOAD_CAP : FRAME_LEN - 3;
    localparam int CHECK_POS   = FRAME_LEN - 2;   // checksum word
    localparam int FOOTER_POS  = FRAME_LEN - 1;   // last word of a frame

    // one result item as seen on the output ports
    typedef struct {
        logic [POS_W-1:0]   idx;
        logic [WORD_W-1:0]  value;
        logic               ok;
        logic [1:0]         err;
        logic               last;
        logic [COUNT_W-1:0] good;
        logic [COUNT_W-1:0] dropped;
    } frame_item_t;

    // payload patterns for built frames
    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES,
        FILL_EXTREMES
    } fill_t;

    // sender pacing
    typedef enum int {
        PACE_BURSTS,
        PACE_FLAT,
        PACE_SPARSE
    } pace_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [BYTE_W-1:0]    rx_byte = '0;
    logic                 write_enable = 1'b0;
    logic [CFG_IDX_W-1:0] write_index = twfd_pkg::REG_HEADER;
    logic [WORD_W-1:0]    write_data = '0;
    logic                 strobe;
    logic [POS_W-1:0]     word_index;
    logic [WORD_W-1:0]    word_value;
    logic                 frame_ok;
    logic [1:0]           error_code;
    logic                 last_item;
    logic [COUNT_W-1:0]   good_frames;
    logic [COUNT_W-1:0]   dropped_frames;

    // Checksum contribution of one word: words 24 and 25 go in unsigned,
    // the rest sign-extended, all into a 40-bit two's complement sum.
    function automatic logic [SUM_W-1:0] sum_term(logic [POS_W-1:0] pos, logic [WORD_W-1:0] w);
        if (pos == twfd_pkg::UNSIGNED_POS_A || pos == twfd_pkg::UNSIGNED_POS_B)
            return {{(SUM_W - WORD_W){1'b0}}, w};
        return {{(SUM_W - WORD_W){w[WORD_W-1]}}, w};
    endfunction

    // Low 31 bits plus the arithmetically shifted high part, modulo 2^32.
    function automatic logic [WORD_W-1:0] fold_sum(logic [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] high;
        high = $signed(s) >>> 31;
        return {1'b0, s[30:0]} + high[WORD_W-1:0];
    endfunction

    class frame_scoreboard;
        frame_item_t        expected_q[$];
        int                 mismatches;
        logic [WORD_W-1:0]  header_reg;
        logic [WORD_W-1:0]  footer_reg;
        logic [WORD_W-1:0]  hunt_window;
        logic [WORD_W-1:0]  word_shift;
        logic               hunting;
        logic [1:0]         byte_cnt;
        logic [POS_W-1:0]   word_pos;
        logic [WORD_W-1:0]  store_copy [STORE_DEPTH];
        logic [SUM_W-1:0]   running_sum;
        logic [COUNT_W-1:0] good_cnt;
        logic [COUNT_W-1:0] drop_cnt;

        function new();
            mismatches  = 0;
            header_reg  = twfd_pkg::HEADER_RESET;
            footer_reg  = twfd_pkg::FOOTER_RESET;
            hunt_window = '0;
            word_shift  = '0;
            hunting     = 1'b1;
            byte_cnt    = '0;
            word_pos    = '0;
            running_sum = '0;
            good_cnt    = '0;
            drop_cnt    = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
            if (idx == twfd_pkg::REG_HEADER)
                header_reg = val;
            else if (idx == twfd_pkg::REG_FOOTER)
                footer_reg = val;
        endfunction

        // advance the deframer by one accepted byte, queueing its items
        function void note_byte(logic [BYTE_W-1:0] b);
            logic [WORD_W-1:0]   w;
            logic [POS_W-1:0]    pos;
            twfd_pkg::err_code_t verdict;
            frame_item_t         item;
            if (hunting)
            begin
                hunt_window = {b, hunt_window[WORD_W-1:BYTE_W]};
                if (hunt_window == header_reg)
                begin
                    store_copy[0] = hunt_window;
                    hunting     = 1'b0;
                    word_pos    = POS_W'(1);
                    byte_cnt    = '0;
                    word_shift  = '0;
                    running_sum = '0;
                end
                return;
            end
            word_shift = {b, word_shift[WORD_W-1:BYTE_W]};
            byte_cnt   = byte_cnt + 2'd1;
            if (byte_cnt != 2'd0)
                return;
            w   = word_shift;
            pos = word_pos;
            store_copy[pos] = w;
            if (pos >= 1 && int'(pos) <= PAYLOAD_LEN)
                running_sum = running_sum + sum_term(pos, w);
            if (int'(pos) + 1 < FRAME_LEN)
            begin
                word_pos = pos + 1'b1;
                return;
            end
            // footer test takes priority over the checksum test
            if (w != footer_reg)
                verdict = twfd_pkg::ERR_FOOTER;
            else if (fold_sum(running_sum) != store_copy[CHECK_POS])
                verdict = twfd_pkg::ERR_CHECKSUM;
            else
                verdict = twfd_pkg::ERR_NONE;
            hunting     = 1'b1;
            hunt_window = '0;
            word_pos    = '0;
            byte_cnt    = '0;
            word_shift  = '0;
            running_sum = '0;
            if (verdict != twfd_pkg::ERR_NONE)
            begin
                if (drop_cnt != '1)
                    drop_cnt = drop_cnt + 1'b1;
                item = '{idx: '0, value: '0, ok: 1'b0, err: verdict, last: 1'b1,
                         good: good_cnt, dropped: drop_cnt};
                expected_q.push_back(item);
                return;
            end
            if (good_cnt != '1)
                good_cnt = good_cnt + 1'b1;
            for (int k = 1; k <= PAYLOAD_LEN; k++)
            begin
                item = '{idx: k[POS_W-1:0], value: store_copy[k], ok: 1'b1,
                         err: twfd_pkg::ERR_NONE, last: (k == PAYLOAD_LEN),
                         good: good_cnt, dropped: drop_cnt};
                expected_q.push_back(item);
            end
        endfunction

        function void compare(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_item(frame_item_t got);
            frame_item_t want;
            if (expected_q.size() == 0)
            begin
                $error("item with no expectation pending: index %0d value 0x%0h",
                       got.idx, got.value);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            compare("word_index", WORD_W'(want.idx), WORD_W'(got.idx));
            compare("word_value", want.value, got.value);
            compare("frame_ok", WORD_W'(want.ok), WORD_W'(got.ok));
            compare("error_code", WORD_W'(want.err), WORD_W'(got.err));
            compare("last_item", WORD_W'(want.last), WORD_W'(got.last));
            compare("good_frames", WORD_W'(want.good), WORD_W'(got.good));
            compare("dropped_frames", WORD_W'(want.dropped), WORD_W'(got.dropped));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    frame_scoreboard   board;
    frame_item_t       seen;
    logic [BYTE_W-1:0] tx_bytes[$];     // bytes waiting to be offered
    logic [WORD_W-1:0] cur_header;      // register values used to build frames
    logic [WORD_W-1:0] cur_footer;
    pace_t             pace;
    int                burst_left;

    telemetry_word_frame_deframer_unit #(
        .FRAME_WORDS    (FRAME_LEN)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .rx_byte        (rx_byte),
        .write_enable   (write_enable),
        .write_index    (write_index),
        .write_data     (write_data),
        .strobe         (strobe),
        .word_index     (word_index),
        .word_value     (word_value),
        .frame_ok       (frame_ok),
        .error_code     (error_code),
        .last_item      (last_item),
        .good_frames    (good_frames),
        .dropped_frames (dropped_frames)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sample at the edge: values seen here are those of the cycle just
    // ended, so results are checked before the byte taken at the same edge
    // is fed to the predictor.
    always @(posedge clk)
    begin
        if (rst_n && strobe === 1'b1)
        begin
            seen.idx     = word_index;
            seen.value   = word_value;
            seen.ok      = frame_ok;
            seen.err     = error_code;
            seen.last    = last_item;
            seen.good    = good_frames;
            seen.dropped = dropped_frames;
            board.check_item(seen);
        end
        if (rst_n && start === 1'b1 && busy === 1'b0)
            board.note_byte(rx_byte);
    end

    // mostly plain random words, with all-zero, all-one and the signed extremes mixed in
    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 11))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // little-endian, least significant byte first on the wire
    function automatic void push_word(logic [WORD_W-1:0] w);
        for (int i = 0; i < 4; i++)
            tx_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void push_noise(int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 7))
                0:       tx_bytes.push_back(8'h00);
                1:       tx_bytes.push_back(8'hFF);
                default: tx_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    // Whole frame. lead is the number of header bytes sent: fewer than
    // four suffice after a frame end when the header's low bytes are zero,
    // since the hunt window restarts from zero.
    function automatic void build_frame(int lead, fill_t fill, bit bad_sum, bit bad_footer);
        logic [WORD_W-1:0] w;
        logic [SUM_W-1:0]  sum;
        sum = '0;
        for (int i = 4 - lead; i < 4; i++)
            tx_bytes.push_back(cur_header[8*i +: 8]);
        for (int p = 1; p < CHECK_POS; p++)
        begin
            case (fill)
                FILL_ZERO:     w = '0;
                FILL_ONES:     w = '1;
                FILL_EXTREMES: w = p[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                default:       w = random_word();
            endcase
            if (p <= PAYLOAD_LEN)
                sum = sum + sum_term(p[POS_W-1:0], w);
            push_word(w);
        end
        w = fold_sum(sum);
        if (bad_sum)
            w = w ^ ($urandom | 32'd1);
        push_word(w);
        w = cur_footer;
        if (bad_footer)
            w = w ^ ($urandom | 32'd1);
        push_word(w);
    endfunction

    // Offer every queued byte. start stays high from one byte to the next
    // within a burst; gaps between bursts follow the current pacing.
    task automatic drive_bytes();
        logic [BYTE_W-1:0] b;
        int gap;
        while (tx_bytes.size() > 0)
        begin
            b = tx_bytes.pop_front();
            start   <= 1'b1;
            rx_byte <= b;
            do @(posedge clk); while (busy !== 1'b0);
            burst_left--;
            if (burst_left <= 0 && tx_bytes.size() > 0)
            begin
                case (pace)
                    PACE_FLAT:
                    begin
                        gap        = 0;
                        burst_left = 1000;
                    end
                    PACE_SPARSE:
                    begin
                        gap        = $urandom_range(1, 40);
                        burst_left = $urandom_range(1, 8);
                    end
                    default:
                    begin
                        gap        = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40)
                                                                 : $urandom_range(1, 4);
                        burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 40);
                    end
                endcase
                if (gap > 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        start <= 1'b0;
    endtask

    // Both registers back to back; the predictor takes each at its edge.
    task automatic write_regs(logic [WORD_W-1:0] hdr, logic [WORD_W-1:0] ftr);
        write_enable <= 1'b1;
        write_index  <= twfd_pkg::REG_HEADER;
        write_data   <= hdr;
        @(posedge clk);
        board.set_reg(twfd_pkg::REG_HEADER, hdr);
        write_index  <= twfd_pkg::REG_FOOTER;
        write_data   <= ftr;
        @(posedge clk);
        board.set_reg(twfd_pkg::REG_FOOTER, ftr);
        write_enable <= 1'b0;
        cur_header = hdr;
        cur_footer = ftr;
    endtask

    // One edge first so the last byte has reached the predictor, then
    // drain, then let a byte still in its evaluate cycle settle.
    task automatic wait_idle();
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        board      = new();
        cur_header = twfd_pkg::HEADER_RESET;
        cur_footer = twfd_pkg::FOOTER_RESET;
        pace       = PACE_BURSTS;
        burst_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: noise ahead of one full random frame
        push_noise(20);
        build_frame(4, FILL_RANDOM, 1'b0, 1'b0);
        drive_bytes();
        wait_idle();

        // all-zero header: right after a frame end a single zero byte
        // opens a frame, and what follows is gathered as frame words
        pace = PACE_SPARSE;
        write_regs(32'h0000_0000, $urandom);
        push_word(cur_header);
        push_noise(24);
        drive_bytes();
        wait_idle();

        repeat (2 * PAYLOAD_LEN) @(posedge clk);
        if (board.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: filelist.f
src/twfd_pkg.sv
src/twfd_ctrl.sv
src/twfd_datapath.sv
src/telemetry_word_frame_deframer_unit.sv
tb/tb_top.sv
